[rtl/core/bfca_pkg.sv]
// bfca_pkg: shared types and constants of the best-fit coalescing allocator
// used by best_fit_coalescing_allocator and its port checker; no dependencies

package bfca_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SUM_W      = ADDR_W + 2;
    localparam int SHIFT_W    = 5;

    localparam logic [LEN_W-1:0] SPACE   = {1'b1, {ADDR_W{1'b0}}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] MODE_RESET  = 2'd0;
    localparam logic [1:0] MODE_ALLOC  = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

[rtl/core/best_fit_coalescing_allocator.sv]
// best_fit_coalescing_allocator: free-list allocator with best fit and coalescing
// free blocks live in one synchronous single-read memory; depends on bfca_pkg
//
// The block keeps a table of free blocks (start, length) sorted by start and a
// high-water mark. Each item is a request: reset the list, allocate or free.
// One result item comes back for each request. An allocate or a free scans the
// table through the memory read port, one entry per cycle. When a block must be
// removed or a free must be inserted, the entries above it are moved one per
// cycle through the same port. After reset the block writes the initial
// whole-space entry before it takes the first item. The alignment register must
// be written over the cfg port only while the block is idle; the block itself
// does not enforce this.

module best_fit_coalescing_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bfca_pkg::SHIFT_W-1:0] cfg_align_shift,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [bfca_pkg::ADDR_W-1:0]  req_offset,
    input  logic [bfca_pkg::ADDR_W-1:0]  req_size,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfca_pkg::ADDR_W-1:0]  alloc_offset,
    output logic [1:0]                   status,
    output logic [bfca_pkg::LEN_W-1:0]   high_water
);

    localparam int IDX_W  = bfca_pkg::IDX_W;
    localparam int CNT_W  = bfca_pkg::CNT_W;
    localparam int ADDR_W = bfca_pkg::ADDR_W;
    localparam int LEN_W  = bfca_pkg::LEN_W;
    localparam int SUM_W  = bfca_pkg::SUM_W;

    // sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FREAD = 3'd3;
    localparam logic [2:0] S_FNEXT = 3'd4;
    localparam logic [2:0] S_DN    = 3'd5;
    localparam logic [2:0] S_UP    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // saturate a wide length sum to the length range
    function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] s);
        logic [LEN_W-1:0] r;
        begin
            r = (s > {1'b0, bfca_pkg::LEN_MAX}) ? bfca_pkg::LEN_MAX : s[LEN_W-1:0];
            return r;
        end
    endfunction

    // free block table
    bfca_pkg::entry_t mem [bfca_pkg::MAX_BLOCKS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    bfca_pkg::entry_t  mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    bfca_pkg::entry_t  mem_rdata;

    logic [2:0]                   state_reg, state_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [ADDR_W-1:0]            off_reg, off_next;
    logic [LEN_W-1:0]             size_reg, size_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [LEN_W-1:0]             peak_reg, peak_next;
    logic [bfca_pkg::SHIFT_W-1:0] align_reg;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         found_reg, found_next;
    logic [CNT_W-1:0]             best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]            best_start_reg, best_start_next;
    logic [LEN_W-1:0]             best_len_reg, best_len_next;
    logic [LEN_W-1:0]             newlen_reg, newlen_next;
    logic                         pos_found_reg, pos_found_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;
    logic [CNT_W-1:0]             sh_reg, sh_next;
    logic [ADDR_W-1:0]            res_off_reg, res_off_next;
    logic [1:0]                   res_st_reg, res_st_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]            out_off_reg, out_off_next;
    logic [1:0]                   out_st_reg, out_st_next;
    logic [LEN_W-1:0]             out_hw_reg, out_hw_next;

    // request size rounding
    logic [LEN_W-1:0] align_mask;
    logic [LEN_W-1:0] round_sum;
    logic [LEN_W-1:0] round_size;

    // scan datapath
    logic [SUM_W-1:0] rd_end;
    logic [SUM_W-1:0] free_end;
    logic             hit_a;
    logic             hit_b;
    logic [LEN_W-1:0] merged_len;
    logic [SUM_W-1:0] alloc_end;
    logic [LEN_W-1:0] alloc_left;
    logic [LEN_W-1:0] alloc_end_sat;
    logic [SUM_W-1:0] next_sum;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    assign align_mask = (LEN_W'(1) << align_reg) - LEN_W'(1);
    assign round_sum  = {1'b0, req_size} + align_mask;
    assign round_size = round_sum & ~align_mask;

    assign rd_end     = SUM_W'(mem_rdata.start) + SUM_W'(mem_rdata.len);
    assign free_end   = SUM_W'(off_reg) + SUM_W'(size_reg);
    assign hit_a      = (rd_end == SUM_W'(off_reg));
    assign hit_b      = (free_end == SUM_W'(mem_rdata.start));
    assign merged_len = sat_len(SUM_W'(mem_rdata.len) + SUM_W'(size_reg));

    assign alloc_end     = SUM_W'(best_start_reg) + SUM_W'(size_reg);
    assign alloc_left    = best_len_reg - size_reg;
    assign alloc_end_sat = sat_len(alloc_end);
    assign next_sum      = SUM_W'(best_start_reg) + SUM_W'(newlen_reg);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        newlen_next     = newlen_reg;
        pos_found_next  = pos_found_reg;
        pos_next        = pos_reg;
        sh_next         = sh_reg;
        res_off_next    = res_off_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_off_next    = out_off_reg;
        out_st_next     = out_st_reg;
        out_hw_next     = out_hw_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                // whole space as the only free block
                mem_we          = 1'b1;
                mem_wdata.start = '0;
                mem_wdata.len   = bfca_pkg::SPACE;
                count_next      = CNT_W'(1);
                state_next      = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next      = mode;
                    off_next       = req_offset;
                    size_next      = round_size;
                    res_off_next   = '0;
                    res_st_next    = bfca_pkg::ST_OK;
                    issue_next     = '0;
                    found_next     = 1'b0;
                    pos_found_next = 1'b0;
                    if (mode == bfca_pkg::MODE_ALLOC || mode == bfca_pkg::MODE_FREE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        if (mode == bfca_pkg::MODE_RESET)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.start = '0;
                            mem_wdata.len   = bfca_pkg::SPACE;
                            count_next      = CNT_W'(1);
                            peak_next       = '0;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, evaluate the entry read last cycle
                if (issue_reg < count_reg)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg;
                end

                if (rd_valid_reg)
                begin
                    if (mode_reg == bfca_pkg::MODE_ALLOC)
                    begin
                        if (mem_rdata.len >= size_reg &&
                            (!found_reg || mem_rdata.len < best_len_reg))
                        begin
                            found_next      = 1'b1;
                            best_idx_next   = rd_idx_reg;
                            best_start_next = mem_rdata.start;
                            best_len_next   = mem_rdata.len;
                        end
                    end
                    else
                    begin
                        if (!pos_found_reg && mem_rdata.start >= off_reg)
                        begin
                            pos_found_next = 1'b1;
                            pos_next       = rd_idx_reg;
                        end
                        if (hit_a)
                        begin
                            // region follows this block: grow it, maybe join the next
                            best_idx_next   = rd_idx_reg;
                            best_start_next = mem_rdata.start;
                            newlen_next     = merged_len;
                            if (rd_idx_reg + CNT_W'(1) < count_reg)
                            begin
                                state_next = S_FREAD;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = rd_idx_reg[IDX_W-1:0];
                                mem_wdata.start = mem_rdata.start;
                                mem_wdata.len   = merged_len;
                                state_next      = S_DONE;
                            end
                        end
                        else if (hit_b)
                        begin
                            // region precedes this block; the earlier block cannot touch it
                            mem_we          = 1'b1;
                            mem_waddr       = rd_idx_reg[IDX_W-1:0];
                            mem_wdata.start = off_reg;
                            mem_wdata.len   = merged_len;
                            state_next      = S_DONE;
                        end
                    end
                end
                else if (issue_reg == count_reg)
                begin
                    // scan complete
                    rd_valid_next = 1'b0;
                    if (mode_reg == bfca_pkg::MODE_ALLOC)
                    begin
                        if (!found_reg)
                        begin
                            res_st_next = bfca_pkg::ST_NOFIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            res_off_next = best_start_reg;
                            if (alloc_end_sat > peak_reg)
                            begin
                                peak_next = alloc_end_sat;
                            end
                            if (alloc_left == '0 || alloc_end[SUM_W-1:ADDR_W] != '0)
                            begin
                                sh_next    = best_idx_reg + CNT_W'(1);
                                state_next = S_DN;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = best_idx_reg[IDX_W-1:0];
                                mem_wdata.start = alloc_end[ADDR_W-1:0];
                                mem_wdata.len   = alloc_left;
                                state_next      = S_DONE;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg >= CNT_W'(bfca_pkg::MAX_BLOCKS))
                        begin
                            res_st_next = bfca_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            if (!pos_found_reg)
                            begin
                                pos_next = count_reg;
                            end
                            sh_next    = count_reg;
                            state_next = S_UP;
                        end
                    end
                end
            end

            S_FREAD:
            begin
                mem_raddr  = IDX_W'(best_idx_reg + CNT_W'(1));
                state_next = S_FNEXT;
            end

            S_FNEXT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = best_idx_reg[IDX_W-1:0];
                mem_wdata.start = best_start_reg;
                if (next_sum == SUM_W'(mem_rdata.start))
                begin
                    // grown block reaches the next one: join and drop the next
                    mem_wdata.len = sat_len(SUM_W'(newlen_reg) + SUM_W'(mem_rdata.len));
                    sh_next       = best_idx_reg + CNT_W'(2);
                    state_next    = S_DN;
                end
                else
                begin
                    mem_wdata.len = newlen_reg;
                    state_next    = S_DONE;
                end
            end

            S_DN:
            begin
                // move entries down by one, starting at sh_reg
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(rd_idx_reg - CNT_W'(1));
                    mem_wdata = mem_rdata;
                end
                if (sh_reg < count_reg)
                begin
                    mem_raddr     = sh_reg[IDX_W-1:0];
                    rd_idx_next   = sh_reg;
                    sh_next       = sh_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_UP:
            begin
                // move entries up by one from the top down to the insert point
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(rd_idx_reg + CNT_W'(1));
                    mem_wdata = mem_rdata;
                end
                if (sh_reg > pos_reg)
                begin
                    mem_raddr     = IDX_W'(sh_reg - CNT_W'(1));
                    rd_idx_next   = sh_reg - CNT_W'(1);
                    sh_next       = sh_reg - CNT_W'(1);
                    rd_valid_next = 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = pos_reg[IDX_W-1:0];
                    mem_wdata.start = off_reg;
                    mem_wdata.len   = size_reg;
                    count_next      = count_reg + CNT_W'(1);
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    out_hw_next    = peak_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            mode_reg       <= '0;
            off_reg        <= '0;
            size_reg       <= '0;
            count_reg      <= '0;
            peak_reg       <= '0;
            align_reg      <= '0;
            issue_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            newlen_reg     <= '0;
            pos_found_reg  <= 1'b0;
            pos_reg        <= '0;
            sh_reg         <= '0;
            res_off_reg    <= '0;
            res_st_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_off_reg    <= '0;
            out_st_reg     <= '0;
            out_hw_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            off_reg        <= off_next;
            size_reg       <= size_next;
            count_reg      <= count_next;
            peak_reg       <= peak_next;
            issue_reg      <= issue_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            newlen_reg     <= newlen_next;
            pos_found_reg  <= pos_found_next;
            pos_reg        <= pos_next;
            sh_reg         <= sh_next;
            res_off_reg    <= res_off_next;
            res_st_reg     <= res_st_next;
            out_valid_reg  <= out_valid_next;
            out_off_reg    <= out_off_next;
            out_st_reg     <= out_st_next;
            out_hw_reg     <= out_hw_next;
            if (cfg_valid)
            begin
                align_reg <= cfg_align_shift;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign alloc_offset = out_off_reg;
    assign status       = out_st_reg;
    assign high_water   = out_hw_reg;

endmodule

[rtl/core/bfca_checker.sv]
// bfca_checker: port-level assertions for best_fit_coalescing_allocator
// depends on bfca_pkg; bound to the top level below

module bfca_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bfca_pkg::ADDR_W-1:0] alloc_offset,
    input logic [1:0]                  status,
    input logic [bfca_pkg::LEN_W-1:0]  high_water
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(alloc_offset) &&
            $stable(status) && $stable(high_water))
        else $error("stalled result item changed");

    // a failed request grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bfca_pkg::ST_OK |-> alloc_offset == '0)
        else $error("nonzero offset on failed request");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while busy");

endmodule

bind best_fit_coalescing_allocator bfca_checker u_bfca_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alloc_offset (alloc_offset),
    .status       (status),
    .high_water   (high_water)
);
